@@ hw/rtl/bba_pkg.sv @@
// shared constants, codes and control types of the bitmap block allocator
package bba_pkg;

  // field widths
  localparam int ID_W   = 12;
  localparam int FB_W   = 12;
  localparam int BC_W   = 13;
  localparam int ST_W   = 2;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // default sizing
  localparam int NUM_BLOCKS_DEF = 4096;
  localparam int WORD_BITS_DEF  = 32;

  // register reset values
  localparam logic [FB_W-1:0] FB_RESET = 12'd0;
  localparam logic [BC_W-1:0] BC_RESET = 13'd4096;

  // request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // register index (address bit 2)
  localparam logic REG_FIRST_BLOCK = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_SCAN,
    S_FREE_RD,
    S_FREE_WR,
    S_DONE
  } bba_state_t;

  // controller to datapath
  typedef struct packed {
    logic load_alloc;
    logic load_free;
    logic step;
    logic clr;
    logic wr_alloc;
    logic wr_free;
    logic set_full;
    logic set_range;
    logic out_load;
  } bba_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fb_out;
    logic id_out;
    logic hit;
    logic last_word;
    logic clr_last;
  } bba_sts_t;

endpackage

@@ hw/rtl/bba_req_if.sv @@
// request channel: opcode and block index
interface bba_req_if;
  import bba_pkg::*;

  logic            valid;
  logic            ready;
  logic            op;
  logic [ID_W-1:0] block_id;

  modport source (output valid, op, block_id, input ready);
  modport sink   (input valid, op, block_id, output ready);
endinterface

@@ hw/rtl/bba_rsp_if.sv @@
// response channel: allocated index and status
interface bba_rsp_if;
  import bba_pkg::*;

  logic            valid;
  logic            ready;
  logic [ID_W-1:0] alloc_id;
  logic [ST_W-1:0] status;

  modport source (output valid, alloc_id, status, input ready);
  modport sink   (input valid, alloc_id, status, output ready);
endinterface

@@ hw/rtl/bba_ram.sv @@
// generic single-write, single-read ram with registered read data
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/bba_dp.sv @@
// allocator datapath: bitmap ram, word scan, first-free search and result registers
module bba_dp #(
  parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF,
  parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bba_pkg::bba_cmd_t         cmd,
  output bba_pkg::bba_sts_t         sts,
  input  logic [bba_pkg::ID_W-1:0]  in_block_id,
  input  logic [bba_pkg::FB_W-1:0]  first_block,
  input  logic [bba_pkg::BC_W-1:0]  block_count,
  output logic [bba_pkg::ID_W-1:0]  out_alloc_id,
  output logic [bba_pkg::ST_W-1:0]  out_status
);
  import bba_pkg::*;

  // WORD_BITS is a power of two, so word/bit split is a shift and a mask
  localparam int WB_LOG    = $clog2(WORD_BITS);
  localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CW        = AW + 1;
  localparam int NB_W      = $clog2(NUM_BLOCKS) + 1;
  localparam int LW        = (NB_W > BC_W) ? NB_W : BC_W;
  localparam int XW        = ((CW + WB_LOG) > LW) ? (CW + WB_LOG) : LW;

  logic [XW-1:0]        limit;
  logic [XW-1:0]        fb_x;
  logic [XW-1:0]        id_x;
  logic [CW-1:0]        end_words;
  logic [CW-1:0]        ws;
  logic [CW-1:0]        idw;
  logic [WB_LOG-1:0]    fb_lo;
  logic [WB_LOG-1:0]    lim_lo;

  logic [CW-1:0]        word_r;
  logic [CW-1:0]        eval_r;
  logic [WB_LOG-1:0]    bit_r;
  logic [ID_W-1:0]      res_id_r;
  status_t              res_st_r;
  logic [ID_W-1:0]      out_id_r;
  status_t              out_st_r;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;

  logic                 first_w;
  logic                 last_w;
  logic [WORD_BITS-1:0] cand;
  logic [WORD_BITS-1:0] pick;
  logic [WORD_BITS-1:0] set_bits;
  logic [WORD_BITS-1:0] clr_bits;
  logic [WB_LOG-1:0]    hit_idx;
  logic [XW-1:0]        hit_blk;

  // effective block count and range checks
  assign limit     = (XW'(block_count) > XW'(NUM_BLOCKS)) ? XW'(NUM_BLOCKS)
                                                          : XW'(block_count);
  assign fb_x      = XW'(first_block);
  assign id_x      = XW'(in_block_id);
  assign end_words = CW'((limit + XW'(WORD_BITS - 1)) >> WB_LOG);
  assign ws        = CW'(first_block >> WB_LOG);
  assign idw       = CW'(in_block_id >> WB_LOG);
  assign fb_lo     = first_block[WB_LOG-1:0];
  assign lim_lo    = limit[WB_LOG-1:0];

  // first-free search over the word that is being evaluated
  assign first_w = (eval_r == ws);
  assign last_w  = ((eval_r + CW'(1)) >= end_words);

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      cand[j] = !ram_rdata[WORD_BITS-1-j]
                && (!first_w || (WB_LOG'(j) >= fb_lo))
                && (!last_w || (lim_lo == '0) || (WB_LOG'(j) < lim_lo));
    end
  end

  // isolate lowest candidate, then encode it
  assign pick = cand & (~cand + WORD_BITS'(1));

  always_comb begin
    hit_idx = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (pick[j]) begin
        hit_idx = hit_idx | WB_LOG'(j);
      end
    end
  end

  // msb-first bit masks for set and clear
  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      set_bits[WORD_BITS-1-j] = pick[j];
      clr_bits[WORD_BITS-1-j] = (bit_r == WB_LOG'(j));
    end
  end

  assign hit_blk = (XW'(eval_r) << WB_LOG) | XW'(hit_idx);

  // status to controller
  assign sts.fb_out    = (fb_x >= limit);
  assign sts.id_out    = (id_x >= limit);
  assign sts.hit       = |cand;
  assign sts.last_word = last_w;
  assign sts.clr_last  = (word_r == CW'(MAP_WORDS - 1));

  // ram write port
  always_comb begin
    ram_we    = cmd.clr | cmd.wr_alloc | cmd.wr_free;
    ram_waddr = cmd.clr ? word_r[AW-1:0] : eval_r[AW-1:0];
    if (cmd.clr) begin
      ram_wdata = '0;
    end else if (cmd.wr_alloc) begin
      ram_wdata = ram_rdata | set_bits;
    end else begin
      ram_wdata = ram_rdata & ~clr_bits;
    end
  end

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (word_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // word address counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
      eval_r <= '0;
      bit_r  <= '0;
    end else begin
      if (cmd.clr) begin
        word_r <= word_r + CW'(1);
      end else if (cmd.load_alloc) begin
        word_r <= ws;
      end else if (cmd.load_free) begin
        word_r <= idw;
        eval_r <= idw;
        bit_r  <= in_block_id[WB_LOG-1:0];
      end else if (cmd.step) begin
        eval_r <= word_r;
        word_r <= word_r + CW'(1);
      end
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (cmd.wr_alloc) begin
      res_id_r <= hit_blk[ID_W-1:0];
      res_st_r <= ST_OK;
    end else if (cmd.set_full) begin
      res_id_r <= '0;
      res_st_r <= ST_FULL;
    end else if (cmd.set_range) begin
      res_id_r <= '0;
      res_st_r <= ST_RANGE;
    end else if (cmd.wr_free) begin
      res_id_r <= '0;
      res_st_r <= ST_OK;
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_id_r <= res_id_r;
      out_st_r <= res_st_r;
    end
  end

  assign out_alloc_id = out_id_r;
  assign out_status   = out_st_r;

  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr, cmd.wr_alloc, cmd.wr_free}))
    else $error("bitmap ram written by more than one source");

  a_alloc_was_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_alloc |-> ((ram_rdata & set_bits) == '0) && $onehot(set_bits))
    else $error("allocated bit was not a single free bit");

  a_alloc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_alloc |-> (hit_blk >= fb_x) && (hit_blk < limit))
    else $error("allocated block outside first_block and block count");

endmodule

@@ hw/rtl/bba_ctrl.sv @@
// allocator controller: clear pass, request dispatch, scan sequencing, output handshake
module bba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_op,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output bba_pkg::bba_cmd_t  cmd,
  input  bba_pkg::bba_sts_t  sts
);
  import bba_pkg::*;

  bba_state_t state_r;
  bba_state_t state_nxt;
  logic       out_valid_r;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_FREE) begin
            if (sts.id_out) begin
              cmd.set_range = 1'b1;
              state_nxt     = S_DONE;
            end else begin
              cmd.load_free = 1'b1;
              state_nxt     = S_FREE_RD;
            end
          end else begin
            if (sts.fb_out) begin
              cmd.set_full = 1'b1;
              state_nxt    = S_DONE;
            end else begin
              cmd.load_alloc = 1'b1;
              state_nxt      = S_FETCH;
            end
          end
        end
      end
      S_FETCH: begin
        cmd.step  = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.hit) begin
          cmd.wr_alloc = 1'b1;
          state_nxt    = S_DONE;
        end else if (sts.last_word) begin
          cmd.set_full = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_FREE_RD: begin
        state_nxt = S_FREE_WR;
      end
      S_FREE_WR: begin
        cmd.wr_free = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not presented");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE) && (state_r != S_CLEAR))
    else $error("accepted request did not start work");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("result beat dropped while stalled");

endmodule

@@ hw/rtl/bitmap_block_allocator_core.sv @@
// top level of the bitmap first-free block allocator with its register port
//
//   channel  | dir | handshake                     | beat contents
//   in_ch    | in  | valid/ready                   | op, block_id
//   out_ch   | out | valid/ready                   | alloc_id, status
//   cfg      | in  | psel/penable/pwrite, pready=1 | reg 0 first_block, reg 1 block_count
//
// alloc reads bitmap words one per cycle from the word holding first_block, at most
// NUM_BLOCKS/WORD_BITS = 128 by default; the single ram read port sets this rate.
// free reads, modifies and writes back one bitmap word; a rejected request skips the ram.
// after reset a clearing pass zeroes all NUM_BLOCKS/WORD_BITS map words; no
// request beat is taken until it ends, register writes are taken throughout.
// a finished result waits in the output register while the next request is taken.
module bitmap_block_allocator_core #(
  parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF,
  parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  bba_req_if.sink                     in_ch,
  bba_rsp_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bba_pkg::CFG_AW-1:0]  paddr,
  input  logic [bba_pkg::CFG_DW-1:0]  pwdata,
  output logic [bba_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import bba_pkg::*;

  logic [FB_W-1:0] first_block_r;
  logic [BC_W-1:0] block_count_r;
  logic            cfg_wr;
  bba_cmd_t        cmd;
  bba_sts_t        sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_block_r <= FB_RESET;
      block_count_r <= BC_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_FIRST_BLOCK: first_block_r <= pwdata[FB_W-1:0];
        REG_BLOCK_COUNT: block_count_r <= pwdata[BC_W-1:0];
        default:         ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    unique case (paddr[2])
      REG_FIRST_BLOCK: prdata = CFG_DW'(first_block_r);
      REG_BLOCK_COUNT: prdata = CFG_DW'(block_count_r);
      default:         prdata = '0;
    endcase
  end

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.op),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  bba_dp #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_block_id  (in_ch.block_id),
    .first_block  (first_block_r),
    .block_count  (block_count_r),
    .out_alloc_id (out_ch.alloc_id),
    .out_status   (out_ch.status)
  );

endmodule

@@ verif/tb_top.sv @@
// testbench for the bitmap first-free block allocator: directed and random alloc/free
// traffic checked against a bit-level shadow of the used map
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bba_pkg::*;

  localparam int MAP_WORDS   = NUM_BLOCKS_DEF / WORD_BITS_DEF;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 140;

  typedef struct packed {
    logic            op;
    logic [ID_W-1:0] block_id;
  } req_beat_t;

  typedef struct packed {
    logic [ID_W-1:0] alloc_id;
    status_t         status;
  } rsp_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  bba_req_if req_ch ();
  bba_rsp_if rsp_ch ();

  bitmap_block_allocator_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (req_ch),
    .out_ch  (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // clock
  always #4 clk = ~clk;

  // shadow of the allocator state
  logic [WORD_BITS_DEF-1:0] shadow_map [MAP_WORDS];
  logic [FB_W-1:0]          shadow_first;
  logic [BC_W-1:0]          shadow_count;

  req_beat_t req_backlog [$];
  rsp_beat_t awaited_rsp [$];
  req_beat_t next_req;
  rsp_beat_t want_rsp;

  int mismatches = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  bit hold_off_armed = 1'b0;
  bit hold_off_used = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  // blocks the allocator may hand out or free: min(count, NUM_BLOCKS)
  function automatic int usable_limit(int count);
    return (count > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : count;
  endfunction

  // apply one request to the shadow map and return the response it should give
  function automatic rsp_beat_t apply_request(logic op, logic [ID_W-1:0] id);
    rsp_beat_t r;
    int lim;
    int b;
    int pos;
    bit found;
    r.alloc_id = '0;
    r.status = ST_OK;
    lim = usable_limit(int'(shadow_count));
    if (op == OP_ALLOC) begin
      found = 1'b0;
      // lowest free block in [first, limit), msb-first within each word
      for (b = int'(shadow_first); b < lim && !found; b++) begin
        pos = WORD_BITS_DEF - 1 - (b % WORD_BITS_DEF);
        if (!shadow_map[b / WORD_BITS_DEF][pos]) begin
          shadow_map[b / WORD_BITS_DEF][pos] = 1'b1;
          r.alloc_id = b[ID_W-1:0];
          found = 1'b1;
        end
      end
      if (!found) r.status = ST_FULL;
    end else if (int'(id) >= lim) begin
      r.status = ST_RANGE;
    end else begin
      shadow_map[id / WORD_BITS_DEF][WORD_BITS_DEF - 1 - (id % WORD_BITS_DEF)] = 1'b0;
    end
    return r;
  endfunction

  task automatic flag_mismatch(string what, int exp_a, int exp_b, int got_a, int got_b);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0d/%0d got %0d/%0d", what, exp_a, exp_b, got_a, got_b);
  endtask

  // register mirror, follows completed writes
  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_first <= FB_RESET;
      shadow_count <= BC_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_FIRST_BLOCK: shadow_first <= pwdata[FB_W-1:0];
        REG_BLOCK_COUNT: shadow_count <= pwdata[BC_W-1:0];
        default: ;
      endcase
    end
  end

  // request driver, predicts each accepted beat
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      for (int i = 0; i < MAP_WORDS; i++) shadow_map[i] = '0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        awaited_rsp.push_back(apply_request(req_ch.op, req_ch.block_id));
      if (!req_ch.valid || req_ch.ready) begin
        if (req_backlog.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          next_req = req_backlog.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.op <= next_req.op;
          req_ch.block_id <= next_req.block_id;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor and receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (awaited_rsp.size() == 0) begin
          flag_mismatch("unexpected beat", 0, 0, int'(rsp_ch.alloc_id), int'(rsp_ch.status));
        end else begin
          want_rsp = awaited_rsp.pop_front();
          if (rsp_ch.alloc_id !== want_rsp.alloc_id || rsp_ch.status !== want_rsp.status)
            flag_mismatch("response id/status", int'(want_rsp.alloc_id),
                          int'(want_rsp.status), int'(rsp_ch.alloc_id),
                          int'(rsp_ch.status));
        end
      end
      // one long hold-off so the core fills up and stalls its input
      if (hold_left != 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_off_armed && !hold_off_used) begin
        rsp_ch.ready <= 1'b0;
        hold_left <= HOLD_CYCLES;
        hold_off_used <= 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // watchdog on cycles with no beat and no register access
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_req(logic op, int id);
    req_beat_t r;
    r.op = op;
    r.block_id = id[ID_W-1:0];
    req_backlog.push_back(r);
  endtask

  // mostly allocs and frees in or just below the window, some frees anywhere
  function automatic req_beat_t random_request(int first, int lim);
    req_beat_t r;
    int pick;
    int lo;
    pick = $urandom_range(99);
    r.op = OP_ALLOC;
    r.block_id = ID_W'($urandom_range(NUM_BLOCKS_DEF - 1));
    if (pick >= 58) begin
      r.op = OP_FREE;
      if (pick < 90 && lim > 0) begin
        lo = (first > 4) ? first - 4 : 0;
        if (lo >= lim) lo = 0;
        r.block_id = ID_W'($urandom_range(lim - 1, lo));
      end
    end
    return r;
  endfunction

  task automatic wait_drained();
    while (req_backlog.size() != 0 || req_ch.valid || awaited_rsp.size() != 0)
      @(negedge clk);
  endtask

  // register write followed by a readback
  task automatic cfg_write_check(logic idx, logic [CFG_DW-1:0] value);
    logic [CFG_DW-1:0] mask;
    mask = (idx == REG_FIRST_BLOCK) ? (32'd1 << FB_W) - 1 : (32'd1 << BC_W) - 1;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & mask) !== (value & mask))
      flag_mismatch("register readback", int'(idx), int'(value & mask), int'(idx),
                    int'(prdata & mask));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(int first, int count);
    wait_drained();
    cfg_write_check(REG_FIRST_BLOCK, first);
    cfg_write_check(REG_BLOCK_COUNT, count);
    @(negedge clk);
  endtask

  task automatic run_phase(int first, int count, int n, int snd_pct, int rcv_pct);
    int lim;
    set_config(first, count);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    lim = usable_limit(count & 'h1FFF);
    for (int i = 0; i < n; i++) req_backlog.push_back(random_request(first & 'hFFF, lim));
  endtask

  // stimulus
  initial begin
    int fb;
    req_ch.valid = 1'b0;
    req_ch.op = OP_ALLOC;
    req_ch.block_id = '0;
    rsp_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    snd_idle_pct = 29;
    rcv_idle_pct = 69;

    // reset settings: lowest blocks, frees of free and used blocks, id extremes
    queue_req(OP_ALLOC, 'hFFF);
    queue_req(OP_ALLOC, 0);
    queue_req(OP_ALLOC, 'hAAA);
    queue_req(OP_FREE, 1);
    queue_req(OP_ALLOC, 'h555);
    queue_req(OP_FREE, 'hFFF);
    queue_req(OP_FREE, 0);
    queue_req(OP_ALLOC, 0);
    // only the top block in the window
    set_config(4095, 4096);
    queue_req(OP_ALLOC, 0);
    queue_req(OP_ALLOC, 0);
    queue_req(OP_FREE, 4095);
    queue_req(OP_ALLOC, 0);
    // single block window, free past the count
    set_config(0, 1);
    queue_req(OP_ALLOC, 0);
    queue_req(OP_FREE, 1);
    queue_req(OP_FREE, 0);
    // no block managed
    set_config(0, 0);
    queue_req(OP_ALLOC, 0);
    queue_req(OP_FREE, 0);
    // count above the map size saturates
    set_config(10, 8191);
    queue_req(OP_ALLOC, 0);
    queue_req(OP_FREE, 4095);
    // first block beyond the count, free below the first block
    set_config(200, 100);
    queue_req(OP_ALLOC, 0);
    queue_req(OP_FREE, 50);
    // window across a word boundary
    set_config(31, 33);
    queue_req(OP_ALLOC, 0);
    queue_req(OP_ALLOC, 0);
    queue_req(OP_ALLOC, 0);

    // small windows that fill up, with the long receiver hold-off
    fb = $urandom_range(4000);
    run_phase(fb, fb + $urandom_range(64, 8), 110, 29, 69);
    hold_off_armed = 1'b1;
    run_phase(0, $urandom_range(96, 16), 100, 29, 69);
    run_phase($urandom_range(4095), 8191, 80, 69, 29);
    run_phase($urandom_range(4090, 3000), 4096, 90, 69, 29);
    run_phase($urandom_range(60), $urandom_range(64, 1), 60, 69, 29);
    run_phase(0, 0, 20, 0, 0);
    fb = $urandom_range(4000);
    run_phase(fb, fb + $urandom_range(48, 1), 120, 0, 0);
    run_phase(4095, 8191, 20, 0, 0);
    run_phase($urandom_range(4095), $urandom_range(8191, 1), 100, 0, 0);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited_rsp.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/bba_pkg.sv
hw/rtl/bba_req_if.sv
hw/rtl/bba_rsp_if.sv
hw/rtl/bba_ram.sv
hw/rtl/bba_dp.sv
hw/rtl/bba_ctrl.sv
hw/rtl/bitmap_block_allocator_core.sv
verif/tb_top.sv
